FILE: src/stunbr_pkg.sv
// Shared types and constants for the STUN binding response parser.
// No dependencies; imported by stunbr_parse and the core top level.
package stunbr_pkg;

	localparam logic [31:0] COOKIE          = 32'h2112_A442;
	localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
	localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
	localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
	localparam logic [16:0] HEADER_BYTES    = 17'd20;
	localparam logic [16:0] OFFSET_LIMIT    = 17'h1_FFFF;

	// result status codes
	localparam logic [2:0] ST_FOUND        = 3'd0;
	localparam logic [2:0] ST_SHORT        = 3'd1;
	localparam logic [2:0] ST_BAD_COOKIE   = 3'd2;
	localparam logic [2:0] ST_TID_MISMATCH = 3'd3;
	localparam logic [2:0] ST_NO_ADDR      = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_TID_HIGH = 2'd0;
	localparam logic [1:0] CFG_TID_MID  = 2'd1;
	localparam logic [1:0] CFG_TID_LOW  = 2'd2;

	// packed so that status sits in the lowest bits
	typedef struct packed {
		logic        was_xor;
		logic [15:0] public_port;
		logic [31:0] public_ip;
		logic [2:0]  status;
	} stunbr_result_t;

endpackage

FILE: src/stunbr_parse.sv
// Per-byte datagram parser: header checks, attribute walk and result decode.
// Holds the per-datagram state; depends on stunbr_pkg.
module stunbr_parse #(
	parameter int MAX_DATAGRAM = 1500
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 byte_in,
	input  logic                       last_in,
	input  logic [95:0]                tid,
	output stunbr_pkg::stunbr_result_t result
);
	import stunbr_pkg::*;

	localparam int POS_W = $clog2(MAX_DATAGRAM + 1);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      msg_len_q, msg_len_d;
	logic [31:0]      cookie_q, cookie_d;
	logic             mism_q, mism_d;
	logic [16:0]      nas_q, nas_d;
	logic [15:0]      kind_q, kind_d;
	logic [15:0]      alen_q, alen_d;
	logic             stop_q, stop_d;
	logic             cvalid_q, cvalid_d;
	logic             cxor_q, cxor_d;
	logic [31:0]      cip_q, cip_d;
	logic [15:0]      cport_q, cport_d;
	logic [16:0]      cend_q, cend_d;

	logic [16:0] p17;
	logic [16:0] diff;
	logic        room_ok;
	logic [15:0] len_next;
	logic [15:0] skip_len;
	logic [17:0] padded;
	logic [17:0] skip_sum;
	logic [16:0] skip_nas;
	logic [17:0] end_sum;
	logic [16:0] end_sat;
	logic [3:0]  tid_idx;
	logic [6:0]  tid_bit;
	logic [7:0]  tid_byte;
	logic [16:0] n17;

	always_comb begin
		pos_d      = pos_q;
		msg_len_d  = msg_len_q;
		cookie_d   = cookie_q;
		mism_d     = mism_q;
		nas_d      = nas_q;
		kind_d     = kind_q;
		alen_d     = alen_q;
		stop_d     = stop_q;
		cvalid_d   = cvalid_q;
		cxor_d     = cxor_q;
		cip_d      = cip_q;
		cport_d    = cport_q;
		cend_d     = cend_q;

		p17      = 17'(pos_q);
		diff     = p17 - nas_q;
		room_ok  = (18'(nas_q) + 18'd4) <= (18'(HEADER_BYTES) + 18'(msg_len_q));
		len_next = {alen_q[15:8], byte_in};
		skip_len = (diff == 17'd3) ? len_next : alen_q;
		padded   = (18'(skip_len) + 18'd3) & ~18'd3;
		skip_sum = 18'(nas_q) + 18'd4 + padded;
		skip_nas = (skip_sum > 18'(OFFSET_LIMIT)) ? OFFSET_LIMIT : skip_sum[16:0];
		end_sum  = 18'(nas_q) + 18'd4 + 18'(alen_q);
		end_sat  = (end_sum > 18'(OFFSET_LIMIT)) ? OFFSET_LIMIT : end_sum[16:0];
		tid_idx  = 4'(p17[4:0] - 5'd8);
		tid_bit  = 7'd88 - {tid_idx, 3'b000};
		tid_byte = tid[tid_bit +: 8];

		if (pos_q < POS_W'(MAX_DATAGRAM)) begin
			pos_d = pos_q + POS_W'(1);
			if (p17 == 17'd2) begin
				msg_len_d = {byte_in, 8'h00};
			end else if (p17 == 17'd3) begin
				msg_len_d = {msg_len_q[15:8], byte_in};
			end else if (p17 >= 17'd4 && p17 < 17'd8) begin
				cookie_d = {cookie_q[23:0], byte_in};
			end else if (p17 >= 17'd8 && p17 < HEADER_BYTES) begin
				if (byte_in != tid_byte) begin
					mism_d = 1'b1;
				end
			end else if (p17 >= HEADER_BYTES && !stop_q && p17 >= nas_q) begin
				case (diff)
					17'd0: begin
						if (!room_ok) begin
							stop_d = 1'b1;
						end else begin
							kind_d = {byte_in, 8'h00};
						end
					end
					17'd1: kind_d = {kind_q[15:8], byte_in};
					17'd2: alen_d = {byte_in, 8'h00};
					17'd3: begin
						alen_d = len_next;
						if (!((kind_q == ATTR_XOR_MAPPED || kind_q == ATTR_MAPPED)
						      && len_next >= 16'd8)) begin
							nas_d = skip_nas;
						end
					end
					17'd5: begin
						if (byte_in != FAMILY_IPV4) begin
							nas_d = skip_nas;
						end
					end
					17'd6, 17'd7: cport_d = {cport_q[7:0], byte_in};
					17'd8, 17'd9, 17'd10: cip_d = {cip_q[23:0], byte_in};
					17'd11: begin
						cip_d    = {cip_q[23:0], byte_in};
						cvalid_d = 1'b1;
						cxor_d   = (kind_q == ATTR_XOR_MAPPED);
						cend_d   = end_sat;
						stop_d   = 1'b1;
					end
					default: ;
				endcase
			end
		end

		// final verdict, taken from the state after this byte
		n17    = 17'(pos_d);
		result = '0;
		if (n17 < HEADER_BYTES) begin
			result.status = ST_SHORT;
		end else if (cookie_d != COOKIE) begin
			result.status = ST_BAD_COOKIE;
		end else if (mism_d) begin
			result.status = ST_TID_MISMATCH;
		end else if (cvalid_d && cend_d <= n17) begin
			result.status = ST_FOUND;
			if (cxor_d) begin
				result.public_ip   = cip_d ^ COOKIE;
				result.public_port = cport_d ^ COOKIE[31:16];
				result.was_xor     = 1'b1;
			end else begin
				result.public_ip   = cip_d;
				result.public_port = cport_d;
			end
		end else begin
			result.status = ST_NO_ADDR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			msg_len_q  <= '0;
			cookie_q   <= '0;
			mism_q     <= 1'b0;
			nas_q      <= HEADER_BYTES;
			kind_q     <= '0;
			alen_q     <= '0;
			stop_q     <= 1'b0;
			cvalid_q   <= 1'b0;
			cxor_q     <= 1'b0;
			cip_q      <= '0;
			cport_q    <= '0;
			cend_q     <= '0;
		end else if (step) begin
			if (last_in) begin
				// datagram done: back to the start-of-datagram state
				pos_q      <= '0;
				msg_len_q  <= '0;
				cookie_q   <= '0;
				mism_q     <= 1'b0;
				nas_q      <= HEADER_BYTES;
				kind_q     <= '0;
				alen_q     <= '0;
				stop_q     <= 1'b0;
				cvalid_q   <= 1'b0;
				cxor_q     <= 1'b0;
				cip_q      <= '0;
				cport_q    <= '0;
				cend_q     <= '0;
			end else begin
				pos_q      <= pos_d;
				msg_len_q  <= msg_len_d;
				cookie_q   <= cookie_d;
				mism_q     <= mism_d;
				nas_q      <= nas_d;
				kind_q     <= kind_d;
				alen_q     <= alen_d;
				stop_q     <= stop_d;
				cvalid_q   <= cvalid_d;
				cxor_q     <= cxor_d;
				cip_q      <= cip_d;
				cport_q    <= cport_d;
				cend_q     <= cend_d;
			end
		end
	end

endmodule

FILE: src/stun_binding_response_parser_core.sv
// STUN binding response parser, one datagram byte per cycle.
// Result path: input register, then output register, which drives m_tvalid.
// Throughput: one byte per cycle; a last byte waits in the input register only
// while a previous result is still held unaccepted in the output register.
// Reset returns the parse state to its start-of-datagram values, id registers to zero.
// Depends on stunbr_pkg and stunbr_parse.
module stun_binding_response_parser_core #(
	parameter int MAX_DATAGRAM = 1500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [2:0] status, [34:3] public_ip,
	                               // [50:35] public_port, [51] was_xor, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import stunbr_pkg::*;

	logic           v_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           adv;
	logic [31:0]    tid_high_q, tid_mid_q, tid_low_q;
	stunbr_result_t res;
	stunbr_result_t out_q;
	logic           out_v_q;

	// only a last byte needs room in the output register
	assign adv       = v_s1 && (!last_s1 || !out_v_q || m_tready);
	assign s_tready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {4'b0000, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_high_q <= '0;
			tid_mid_q  <= '0;
			tid_low_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TID_HIGH: tid_high_q <= cfg_data;
				CFG_TID_MID:  tid_mid_q  <= cfg_data;
				CFG_TID_LOW:  tid_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	stunbr_parse #(
		.MAX_DATAGRAM(MAX_DATAGRAM)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.tid     ({tid_high_q, tid_mid_q, tid_low_q}),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_q <= res;
		end
	end

	// a pending last byte must not be overtaken while the result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1 && out_v_q && !m_tready) |-> !s_tready)
		else $error("input taken while last byte blocked");

	// a new result only ever follows a last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s1 && last_s1))
		else $error("result without last byte");

	// address fields are zero unless an address was found
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] != ST_FOUND) |-> (m_tdata[51:3] == '0))
		else $error("address fields set on failure status");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= ST_NO_ADDR))
		else $error("status out of range");

endmodule
